@@ design/rotary_encoder_button_qualifier_macros.svh @@
// ----------------------------------------------------------------------------
// Rotary encoder button qualifier - assertion macros
// Shared concurrent assertion forms, all reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ROTARY_ENCODER_BUTTON_QUALIFIER_MACROS_SVH
`define ROTARY_ENCODER_BUTTON_QUALIFIER_MACROS_SVH

// Condition must hold in the same cycle as the trigger
`define REB_ASSERT_SAME(label, clk, rst, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error(msg);

// Condition must hold in the cycle after the trigger
`define REB_ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

@@ design/reb_pkg.sv @@
// ----------------------------------------------------------------------------
// reb_pkg
// Command codes, register indexes and fixed widths of the encoder qualifier.
// ----------------------------------------------------------------------------
package reb_pkg;

  // Field widths of the channels
  localparam int CMD_W       = 2;
  localparam int LIMIT_W     = 8;
  localparam int GUARD_W     = 8;
  localparam int LONG_W      = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // Register reset values
  localparam logic [LIMIT_W-1:0] MIN_LIMIT_RST     = 8'd0;
  localparam logic [LIMIT_W-1:0] MAX_LIMIT_RST     = 8'd2;
  localparam logic               WRAP_ENABLE_RST   = 1'b1;
  localparam logic [GUARD_W-1:0] LINE_GUARD_RST    = 8'd15;
  localparam logic [GUARD_W-1:0] TURN_GUARD_RST    = 8'd25;
  localparam logic [LONG_W-1:0]  LONG_PRESS_RST    = 16'd500;

  // Item commands
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK   = 2'd0,
    CMD_EDGE_A = 2'd1,
    CMD_EDGE_B = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_t;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MIN_LIMIT   = 3'd0,
    REG_MAX_LIMIT   = 3'd1,
    REG_WRAP_ENABLE = 3'd2,
    REG_LINE_GUARD  = 3'd3,
    REG_TURN_GUARD  = 3'd4,
    REG_LONG_PRESS  = 3'd5
  } cfg_reg_t;

endpackage

@@ design/reb_if.sv @@
// ----------------------------------------------------------------------------
// reb_if
// Valid/ready channels of the encoder qualifier: items, results, config.
// ----------------------------------------------------------------------------

// Input item channel
interface reb_in_if;
  logic                    valid;
  logic                    ready;
  logic [reb_pkg::CMD_W-1:0] cmd;
  logic                    a_level;
  logic                    b_level;
  logic                    button_level;

  modport source (output valid, cmd, a_level, b_level, button_level, input ready);
  modport sink   (input valid, cmd, a_level, b_level, button_level, output ready);
endinterface

// Result channel
interface reb_out_if #(parameter int POSITION_WIDTH = 8);
  logic                      valid;
  logic                      ready;
  logic [POSITION_WIDTH-1:0] position;
  logic                      moved;
  logic                      short_press;
  logic                      long_press;
  logic                      button_down;

  modport source (output valid, position, moved, short_press, long_press, button_down,
                  input ready);
  modport sink   (input valid, position, moved, short_press, long_press, button_down,
                  output ready);
endinterface

// Register write channel
interface reb_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [reb_pkg::CFG_INDEX_W-1:0] index;
  logic [reb_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ design/rotary_encoder_button_qualifier.sv @@
// ----------------------------------------------------------------------------
// rotary_encoder_button_qualifier
// Qualifies encoder edges into a limited position and classifies button
// presses as short or long on millisecond ticks.
// ----------------------------------------------------------------------------
//   channel  | dir | payload                                              | accept
//   items    | in  | cmd, a_level, b_level, button_level                  | valid & ready
//   results  | out | position, moved, short_press, long_press, button_down| valid & ready
//   cfg      | in  | index, data                                          | valid & ready
//
// One result per item, registered in the cycle after the item is accepted.
// An item can be accepted every cycle unless a waiting result stalls it; state updates at the accepting edge.
// items.ready drops only while a result waits and results.ready is low.
// cfg is always ready. Synchronous active-high reset clears the block state and the
// result valid, and loads the register defaults.
// ----------------------------------------------------------------------------
`include "rotary_encoder_button_qualifier_macros.svh"

module rotary_encoder_button_qualifier #(
  parameter int TIME_WIDTH     = 32,
  parameter int POSITION_WIDTH = 8
) (
  input  logic      clk,
  input  logic      rst,
  reb_in_if.sink    items,
  reb_out_if.source results,
  reb_cfg_if.sink   cfg
);

  // Signed width that holds position +/- 1 and both limits
  localparam int SW = ((POSITION_WIDTH > reb_pkg::LIMIT_W) ?
                       POSITION_WIDTH : reb_pkg::LIMIT_W) + 2;

  // Configuration registers
  logic [reb_pkg::LIMIT_W-1:0] min_limit;
  logic [reb_pkg::LIMIT_W-1:0] max_limit;
  logic                        wrap_enable;
  logic [reb_pkg::GUARD_W-1:0] line_guard_ms;
  logic [reb_pkg::GUARD_W-1:0] turn_guard_ms;
  logic [reb_pkg::LONG_W-1:0]  long_press_ms;

  // Block state
  logic [TIME_WIDTH-1:0]     time_now, time_now_next;
  logic [TIME_WIDTH-1:0]     last_a_edge, last_a_edge_next;
  logic [TIME_WIDTH-1:0]     last_b_edge, last_b_edge_next;
  logic [TIME_WIDTH-1:0]     last_turn, last_turn_next;
  logic [TIME_WIDTH-1:0]     press_start, press_start_next;
  logic                      press_tracked, press_tracked_next;
  logic                      long_reported, long_reported_next;
  logic [POSITION_WIDTH-1:0] count_value, count_value_next;

  // Result register
  logic                      out_valid;
  logic [POSITION_WIDTH-1:0] out_position;
  logic                      out_moved, moved_next;
  logic                      out_short, short_next;
  logic                      out_long, long_next;
  logic                      out_down;

  logic              accept;
  reb_pkg::cmd_t     cmd;
  logic [TIME_WIDTH-1:0] time_inc;
  logic [TIME_WIDTH-1:0] line_time;
  logic [TIME_WIDTH-1:0] press_elapsed;
  logic              line_ok, turn_ok, count_ok;
  logic              press_over;

  logic signed [SW-1:0] pos_step, pos_lo, pos_hi, pos_low_fix, pos_final;

  // Handshakes
  assign accept      = items.valid && items.ready;
  assign items.ready = !out_valid || results.ready;
  assign cfg.ready   = 1'b1;
  assign cmd         = reb_pkg::cmd_t'(items.cmd);

  // Guard and hold-time compares
  assign time_inc      = time_now + TIME_WIDTH'(1);
  assign line_time     = (cmd == reb_pkg::CMD_EDGE_A) ? last_a_edge : last_b_edge;
  assign line_ok       = (time_now - line_time) > TIME_WIDTH'(line_guard_ms);
  assign turn_ok       = (time_now - last_turn) > TIME_WIDTH'(turn_guard_ms);
  assign count_ok      = line_ok && !items.a_level && !items.b_level && turn_ok;
  assign press_elapsed = time_inc - press_start;
  assign press_over    = press_elapsed > TIME_WIDTH'(long_press_ms);

  // Position step and limiting: low check first, then high check
  always_comb begin
    pos_lo = $signed({{(SW-reb_pkg::LIMIT_W){1'b0}}, min_limit});
    pos_hi = $signed({{(SW-reb_pkg::LIMIT_W){1'b0}}, max_limit});
    if (cmd == reb_pkg::CMD_EDGE_A) begin
      pos_step = $signed({{(SW-POSITION_WIDTH){1'b0}}, count_value}) + SW'(1);
    end else begin
      pos_step = $signed({{(SW-POSITION_WIDTH){1'b0}}, count_value}) - SW'(1);
    end
    pos_low_fix = (pos_step < pos_lo) ? (wrap_enable ? pos_hi : pos_lo) : pos_step;
    pos_final   = (pos_low_fix > pos_hi) ? (wrap_enable ? pos_lo : pos_hi) : pos_low_fix;
  end

  // Next state for one item
  always_comb begin
    time_now_next      = time_now;
    last_a_edge_next   = last_a_edge;
    last_b_edge_next   = last_b_edge;
    last_turn_next     = last_turn;
    press_start_next   = press_start;
    press_tracked_next = press_tracked;
    long_reported_next = long_reported;
    count_value_next   = count_value;
    moved_next         = 1'b0;
    short_next         = 1'b0;
    long_next          = 1'b0;
    case (cmd)
      reb_pkg::CMD_TICK: begin
        time_now_next = time_inc;
        if (!items.button_level) begin
          if (!press_tracked) begin
            press_start_next   = time_inc;
            press_tracked_next = 1'b1;
          end else if (press_over && !long_reported) begin
            long_reported_next = 1'b1;
            long_next          = 1'b1;
          end
        end else if (press_tracked) begin
          press_tracked_next = 1'b0;
          long_reported_next = 1'b0;
          short_next         = !press_over;
        end
      end
      reb_pkg::CMD_EDGE_A, reb_pkg::CMD_EDGE_B: begin
        if (line_ok) begin
          if (cmd == reb_pkg::CMD_EDGE_A) begin
            last_a_edge_next = time_now;
          end else begin
            last_b_edge_next = time_now;
          end
          if (count_ok) begin
            count_value_next = pos_final[POSITION_WIDTH-1:0];
            last_turn_next   = time_now;
            moved_next       = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      min_limit     <= reb_pkg::MIN_LIMIT_RST;
      max_limit     <= reb_pkg::MAX_LIMIT_RST;
      wrap_enable   <= reb_pkg::WRAP_ENABLE_RST;
      line_guard_ms <= reb_pkg::LINE_GUARD_RST;
      turn_guard_ms <= reb_pkg::TURN_GUARD_RST;
      long_press_ms <= reb_pkg::LONG_PRESS_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (reb_pkg::cfg_reg_t'(cfg.index))
        reb_pkg::REG_MIN_LIMIT:   min_limit     <= cfg.data[reb_pkg::LIMIT_W-1:0];
        reb_pkg::REG_MAX_LIMIT:   max_limit     <= cfg.data[reb_pkg::LIMIT_W-1:0];
        reb_pkg::REG_WRAP_ENABLE: wrap_enable   <= cfg.data[0];
        reb_pkg::REG_LINE_GUARD:  line_guard_ms <= cfg.data[reb_pkg::GUARD_W-1:0];
        reb_pkg::REG_TURN_GUARD:  turn_guard_ms <= cfg.data[reb_pkg::GUARD_W-1:0];
        reb_pkg::REG_LONG_PRESS:  long_press_ms <= cfg.data[reb_pkg::LONG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // State update on accept
  always_ff @(posedge clk) begin
    if (rst) begin
      time_now      <= '0;
      last_a_edge   <= '0;
      last_b_edge   <= '0;
      last_turn     <= '0;
      press_start   <= '0;
      press_tracked <= 1'b0;
      long_reported <= 1'b0;
      count_value   <= '0;
    end else if (accept) begin
      time_now      <= time_now_next;
      last_a_edge   <= last_a_edge_next;
      last_b_edge   <= last_b_edge_next;
      last_turn     <= last_turn_next;
      press_start   <= press_start_next;
      press_tracked <= press_tracked_next;
      long_reported <= long_reported_next;
      count_value   <= count_value_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_position <= count_value_next;
      out_moved    <= moved_next;
      out_short    <= short_next;
      out_long     <= long_next;
      out_down     <= press_tracked_next;
    end
  end

  assign results.valid       = out_valid;
  assign results.position    = out_position;
  assign results.moved       = out_moved;
  assign results.short_press = out_short;
  assign results.long_press  = out_long;
  assign results.button_down = out_down;

  // Checks
  `REB_ASSERT_NEXT(a_result_follows, clk, rst, accept, out_valid, "accepted item gave no result")
  `REB_ASSERT_NEXT(a_edge_no_button, clk, rst,
                   accept && cmd != reb_pkg::CMD_TICK, !out_short && !out_long,
                   "button event on an edge item")
  `REB_ASSERT_NEXT(a_tick_no_move, clk, rst,
                   accept && cmd == reb_pkg::CMD_TICK, !out_moved,
                   "tick counted a turn")
  `REB_ASSERT_SAME(a_long_needs_press, clk, rst, long_reported, press_tracked,
                   "long press flagged with no press tracked")

endmodule
